// ===== hw/rtl/itda_pkg.sv =====
// Package for the integer to decimal ASCII converter.
// Holds operand and digit widths, ASCII codes and the controller state type.
// No dependencies.
package itda_pkg;

  // Width of the input data field and of the operand that is actually used.
  localparam int VALUE_BITS_W = 64;
  localparam int VALUE_WIDTH  = 64;

  // Decimal digits needed for the largest operand: floor(W * log10(2)) + 1.
  localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W      = 4 * NUM_DIGITS;

  // Counter widths: bit counter runs 0..VALUE_WIDTH-1, digit counter holds NUM_DIGITS.
  localparam int CNT_W = $clog2(VALUE_WIDTH);
  localparam int DIG_W = $clog2(NUM_DIGITS + 1);

  // Character codes.
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } itda_state_e;

endpackage

// ===== hw/rtl/integer_to_decimal_ascii_core.sv =====
// Integer to decimal ASCII converter, top level.
// Depends on itda_pkg for widths, character codes and the state type.
//
//   Channel   Dir   Payload                                  Marker
//   s_axis    in    tdata[63:0] value_bits, tuser is_signed  -
//   m_axis    out   tdata[7:0]  ascii_char                   tlast = last_char
//
// A number is handled in steps: the idle state takes the operand, then the
// shift-and-add-3 loop moves one operand bit per cycle into the BCD register,
// then the minus sign of a negative operand goes out, and then each of the NUM_DIGITS
// digits is skipped as a leading zero or sent. The input is ready only when idle.
// A stalled output holds its character and pauses the digit sequencer.
// Reset is asynchronous, active low, and clears the controller and output valid.
module integer_to_decimal_ascii_core
  import itda_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Input stream: tdata = value_bits[63:0]; tuser = is_signed[0].
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [VALUE_BITS_W-1:0] s_axis_tdata_i,
  input  logic [0:0]              s_axis_tuser_i,
  // Output stream: tdata = ascii_char[7:0]; tlast = last_char.
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  output logic [7:0]              m_axis_tdata_o,
  output logic                    m_axis_tlast_o
);

  itda_state_e            state_q, state_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d;
  logic [BCD_W-1:0]       bcd_adj;
  logic [CNT_W-1:0]       bit_cnt_q, bit_cnt_d;
  logic [DIG_W-1:0]       dig_left_q, dig_left_d;
  logic                   minus_q, minus_d;
  logic                   lead_q, lead_d;
  logic                   m_valid_q, m_valid_d;
  logic [7:0]             m_data_q, m_data_d;
  logic                   m_last_q, m_last_d;

  logic                   in_xact;
  logic                   out_free;
  logic [VALUE_WIDTH-1:0] raw;
  logic                   neg;
  logic [3:0]             top_dig;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xact         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  // Operand sign and magnitude.
  assign raw = s_axis_tdata_i[VALUE_WIDTH-1:0];
  assign neg = s_axis_tuser_i[0] && raw[VALUE_WIDTH-1];

  // Add 3 to every BCD digit of 5 or more before the next shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  assign top_dig = bcd_q[BCD_W-1 -: 4];

  // Controller and datapath next state.
  always_comb begin
    state_d    = state_q;
    mag_d      = mag_q;
    bcd_d      = bcd_q;
    bit_cnt_d  = bit_cnt_q;
    dig_left_d = dig_left_q;
    minus_d    = minus_q;
    lead_d     = lead_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    m_last_d   = m_last_q;

    // A taken output transaction frees the output register.
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xact) begin
          mag_d      = neg ? (~raw + VALUE_WIDTH'(1)) : raw;
          minus_d    = neg;
          bcd_d      = '0;
          bit_cnt_d  = '0;
          dig_left_d = DIG_W'(NUM_DIGITS);
          lead_d     = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_d     = {bcd_adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
        mag_d     = {mag_q[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + CNT_W'(1);
        if (bit_cnt_q == CNT_W'(VALUE_WIDTH - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (minus_q) begin
          // The sign goes out before any digit.
          if (out_free) begin
            m_valid_d = 1'b1;
            m_data_d  = ASCII_MINUS;
            m_last_d  = 1'b0;
            minus_d   = 1'b0;
          end
        end else if (lead_q && top_dig == 4'd0 && dig_left_q != DIG_W'(1)) begin
          // Drop a leading zero; the final digit is always sent.
          bcd_d      = {bcd_q[BCD_W-5:0], 4'b0};
          dig_left_d = dig_left_q - DIG_W'(1);
        end else if (out_free) begin
          m_valid_d  = 1'b1;
          m_data_d   = ASCII_ZERO + {4'b0, top_dig};
          m_last_d   = (dig_left_q == DIG_W'(1));
          lead_d     = 1'b0;
          bcd_d      = {bcd_q[BCD_W-5:0], 4'b0};
          dig_left_d = dig_left_q - DIG_W'(1);
          if (dig_left_q == DIG_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      bit_cnt_q  <= '0;
      dig_left_q <= '0;
      minus_q    <= 1'b0;
      lead_q     <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      bit_cnt_q  <= bit_cnt_d;
      dig_left_q <= dig_left_d;
      minus_q    <= minus_d;
      lead_q     <= lead_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    bcd_q    <= bcd_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  // An accepted number starts the conversion at bit zero.
  a_start_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xact |=> (state_q == ST_CONV) && (bit_cnt_q == '0))
    else $error("conversion did not start after input transaction");

  // The digit sequencer never runs with no digits left.
  a_digits_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (dig_left_q != '0))
    else $error("digit sequencer ran past the last digit");

  // A pending character that is not the last one belongs to a number still in work.
  a_nonlast_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_last_q) |-> (state_q == ST_EMIT))
    else $error("non-final character pending outside digit output");

  // Every character is a minus sign or a decimal digit.
  a_char_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> ((m_data_q == ASCII_MINUS) ||
                   ((m_data_q >= ASCII_ZERO) && (m_data_q <= ASCII_ZERO + 8'd9))))
    else $error("output character is not a digit or minus sign");

endmodule
